// ===== design/syn_frame_parity_encoder_assert.svh =====
// Assertion macros for the module that checks its own behavior.
`ifndef SYN_FRAME_PARITY_ENCODER_ASSERT_SVH
`define SYN_FRAME_PARITY_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/sfp_pkg.sv =====
`default_nettype none

package sfp_pkg;

    // Character and coded byte widths.
    localparam int CHAR_W = 7;
    localparam int BYTE_W = 8;

    // Bytes ahead of the payload: sync, sync, count.
    localparam int FRAME_HEAD = 3;

    // Reset value of the sync character.
    localparam logic [CHAR_W-1:0] SYNC_RESET = 7'd22;

    // Write request from the front end into the frame buffer.
    typedef struct packed {
        logic              we;
        logic              push;
        logic [CHAR_W-1:0] data;
    } fill_req_t;

    // Read request from the back end into the frame buffer.
    typedef struct packed {
        logic en;
        logic pop;
    } read_req_t;

    // Odd parity in bit 7: set when the low seven bits hold an even number of ones.
    function automatic logic [BYTE_W-1:0] parity_code(input logic [CHAR_W-1:0] value);
        parity_code = {~^value, value};
    endfunction

endpackage

`default_nettype wire

// ===== design/sfp_front.sv =====
`default_nettype none

module sfp_front #(
    parameter int PAYLOAD_BYTES = 8,
    parameter int CNT_W         = 4,
    parameter int IDX_W         = 3
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [sfp_pkg::CHAR_W-1:0] data_char,
    input  wire logic                     last,
    input  wire logic                     wr_free,
    output sfp_pkg::fill_req_t            fill_req,
    output logic [IDX_W-1:0]              wr_idx,
    output logic [CNT_W-1:0]              push_count
);

    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    logic [CNT_W-1:0] fill_plus;
    logic             accept;
    logic             complete;

    // A request is taken whenever the slot being filled is free.
    assign s_tready = wr_free;
    assign accept   = s_tvalid && wr_free;

    // Classify the request: it either adds to the frame or closes it.
    assign fill_plus  = fill_count_reg + CNT_W'(1);
    assign complete   = (fill_plus == CNT_W'(PAYLOAD_BYTES)) || last;
    assign wr_idx     = fill_count_reg[IDX_W-1:0];
    assign push_count = fill_plus;

    always_comb
    begin
        fill_req.we   = accept;
        fill_req.push = accept && complete;
        fill_req.data = data_char;
    end

    // The fill count restarts once a frame is handed over.
    always_comb
    begin
        fill_count_next = fill_count_reg;
        if (accept)
        begin
            fill_count_next = complete ? '0 : fill_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg <= '0;
        end
        else
        begin
            fill_count_reg <= fill_count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/sfp_frame_buf.sv =====
`default_nettype none

module sfp_frame_buf #(
    parameter int PAYLOAD_BYTES = 8,
    parameter int CNT_W         = 4,
    parameter int IDX_W         = 3
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sfp_pkg::fill_req_t         fill_req,
    input  wire logic [IDX_W-1:0]           wr_idx,
    input  wire logic [CNT_W-1:0]           push_count,
    output logic                            wr_free,
    input  wire sfp_pkg::read_req_t         read_req,
    input  wire logic [IDX_W-1:0]           rd_idx,
    output logic                            head_valid,
    output logic [CNT_W-1:0]                head_count,
    output logic [sfp_pkg::CHAR_W-1:0]      rd_data
);

    // Two frame slots used in turn: one filling while the other drains.
    logic [sfp_pkg::CHAR_W-1:0] mem [2][PAYLOAD_BYTES];
    logic [CNT_W-1:0]           count_reg [2];
    logic [1:0]                 valid_reg;
    logic [1:0]                 valid_next;
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [sfp_pkg::CHAR_W-1:0] rd_data_reg;

    assign wr_free    = !valid_reg[wr_ptr_reg];
    assign head_valid = valid_reg[rd_ptr_reg];
    assign head_count = count_reg[rd_ptr_reg];
    assign rd_data    = rd_data_reg;

    // Slot ownership moves on push and pop.
    always_comb
    begin
        valid_next = valid_reg;
        if (fill_req.push)
        begin
            valid_next[wr_ptr_reg] = 1'b1;
        end
        if (read_req.pop)
        begin
            valid_next[rd_ptr_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (fill_req.push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (read_req.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Payload storage, frame counts and the registered read port.
    always_ff @(posedge clk)
    begin
        if (fill_req.we)
        begin
            mem[wr_ptr_reg][wr_idx] <= fill_req.data;
        end
        if (fill_req.push)
        begin
            count_reg[wr_ptr_reg] <= push_count;
        end
        if (read_req.en)
        begin
            rd_data_reg <= mem[rd_ptr_reg][rd_idx];
        end
    end

endmodule

`default_nettype wire

// ===== design/sfp_back.sv =====
`default_nettype none

module sfp_back #(
    parameter int PAYLOAD_BYTES = 8,
    parameter int CNT_W         = 4,
    parameter int IDX_W         = 3,
    parameter int POS_W         = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [sfp_pkg::CHAR_W-1:0] sync_char,
    input  wire logic                       head_valid,
    input  wire logic [CNT_W-1:0]           head_count,
    input  wire logic [sfp_pkg::CHAR_W-1:0] rd_data,
    output sfp_pkg::read_req_t              read_req,
    output logic [IDX_W-1:0]                rd_idx,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [sfp_pkg::BYTE_W-1:0]      code_byte,
    output logic                            end_of_frame
);

    localparam int CW = sfp_pkg::CHAR_W;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(sfp_pkg::FRAME_HEAD + PAYLOAD_BYTES - 1);
    localparam logic [POS_W-1:0] HEAD_POS = POS_W'(sfp_pkg::FRAME_HEAD);
    localparam logic [POS_W-1:0] COUNT_POS = POS_W'(sfp_pkg::FRAME_HEAD - 1);

    logic                  out_free;
    logic                  issue;
    logic                  at_last;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [POS_W-1:0]      issue_slot;
    logic                  a_valid_reg;
    logic [POS_W-1:0]      a_pos_reg;
    logic [CNT_W-1:0]      a_count_reg;
    logic [POS_W-1:0]      a_slot;
    logic [CW-1:0]         value;
    logic                  m_tvalid_reg;
    logic [sfp_pkg::BYTE_W-1:0] code_byte_reg;
    logic                  end_of_frame_reg;

    // The whole pipe moves when the output register is empty or being taken.
    assign out_free = !m_tvalid_reg || m_tready;
    assign issue    = out_free && head_valid;
    assign at_last  = (pos_reg == LAST_POS);

    // Read the payload slot at the issue position; the slot read register feeds the byte formed in the read stage.
    assign issue_slot = pos_reg - HEAD_POS;
    assign rd_idx     = (pos_reg >= HEAD_POS) ? issue_slot[IDX_W-1:0] : '0;

    always_comb
    begin
        read_req.en  = out_free;
        read_req.pop = issue && at_last;
    end

    // Byte position within the current frame.
    always_comb
    begin
        pos_next = pos_reg;
        if (issue)
        begin
            pos_next = at_last ? '0 : pos_reg + POS_W'(1);
        end
    end

    // Form the seven-bit value for the byte held in the read stage.
    assign a_slot = a_pos_reg - HEAD_POS;

    always_comb
    begin
        if (a_pos_reg < COUNT_POS)
        begin
            value = sync_char;
        end
        else if (a_pos_reg == COUNT_POS)
        begin
            value = CW'(a_count_reg);
        end
        else if (a_slot < POS_W'(a_count_reg))
        begin
            value = rd_data;
        end
        else
        begin
            value = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            a_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (out_free)
            begin
                a_valid_reg  <= issue;
                m_tvalid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers of the read stage and the output register.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            a_pos_reg        <= pos_reg;
            a_count_reg      <= head_count;
            code_byte_reg    <= sfp_pkg::parity_code(value);
            end_of_frame_reg <= (a_pos_reg == LAST_POS);
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign code_byte    = code_byte_reg;
    assign end_of_frame = end_of_frame_reg;

endmodule

`default_nettype wire

// ===== design/syn_frame_parity_encoder.sv =====
// SYN framing encoder with odd parity. Seven-bit characters arrive on the s_
// stream (tlast marks the final character of a message) and are gathered
// PAYLOAD_BYTES at a time into one of two frame slots. A full slot, or a
// character with tlast, closes a frame of PAYLOAD_BYTES + 3 coded bytes on
// the m_ stream: the sync character twice, the payload count, then the
// payload slots with unused ones sent as zero; tlast marks the frame's final
// byte. Each byte carries its value in bits 6..0 and odd parity in bit 7.
// Input accepts a character whenever a slot is free; output runs at one
// byte per cycle while a frame is queued and m_tready is high. Bytes pass
// through the slot read register and the output register. The sync
// character is written through sync_char_wen / sync_char_wdata; the user
// must write it only while idle, as the block does not enforce this. It
// resets to 22.
`default_nettype none

module syn_frame_parity_encoder #(
    parameter int PAYLOAD_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        sync_char_wen,
    input  wire logic [6:0]  sync_char_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [6:0] data_char, [7] zero
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] code_byte
    output logic             m_tlast    // end_of_frame
);

    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int POS_W = $clog2(PAYLOAD_BYTES + sfp_pkg::FRAME_HEAD);

    logic [sfp_pkg::CHAR_W-1:0] sync_char_reg;
    sfp_pkg::fill_req_t         fill_req;
    sfp_pkg::read_req_t         read_req;
    logic [IDX_W-1:0]           wr_idx;
    logic [IDX_W-1:0]           rd_idx;
    logic [CNT_W-1:0]           push_count;
    logic [CNT_W-1:0]           head_count;
    logic                       wr_free;
    logic                       head_valid;
    logic [sfp_pkg::CHAR_W-1:0] rd_data;

    // Sync character register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_char_reg <= sfp_pkg::SYNC_RESET;
        end
        else if (sync_char_wen)
        begin
            sync_char_reg <= sync_char_wdata;
        end
    end

    // Front end: accepts characters and closes frames.
    sfp_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .data_char  (s_tdata[sfp_pkg::CHAR_W-1:0]),
        .last       (s_tlast),
        .wr_free    (wr_free),
        .fill_req   (fill_req),
        .wr_idx     (wr_idx),
        .push_count (push_count)
    );

    // Two-slot frame queue between the front and back ends.
    sfp_frame_buf #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W)
    ) u_frame_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .fill_req   (fill_req),
        .wr_idx     (wr_idx),
        .push_count (push_count),
        .wr_free    (wr_free),
        .read_req   (read_req),
        .rd_idx     (rd_idx),
        .head_valid (head_valid),
        .head_count (head_count),
        .rd_data    (rd_data)
    );

    // Back end: sends the coded bytes of each queued frame.
    sfp_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W),
        .POS_W         (POS_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .sync_char    (sync_char_reg),
        .head_valid   (head_valid),
        .head_count   (head_count),
        .rd_data      (rd_data),
        .read_req     (read_req),
        .rd_idx       (rd_idx),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .code_byte    (m_tdata),
        .end_of_frame (m_tlast)
    );

    // Checks on the block's own logic.
`include "syn_frame_parity_encoder_assert.svh"

    // A frame is only closed into a free slot.
    `SFP_ASSERT_SAME(a_push_free, clk, rst_n, fill_req.push, wr_free)
    // A request marked last always closes its frame.
    `SFP_ASSERT_SAME(a_last_push, clk, rst_n, s_tvalid && s_tready && s_tlast, fill_req.push)
    // Every byte sent carries odd weight.
    `SFP_ASSERT_SAME(a_odd_parity, clk, rst_n, m_tvalid, ^m_tdata)

endmodule

`default_nettype wire
